[sv/ffpa_pkg.sv]
// ----------------------------------------------------------------------------
// ffpa_pkg
// Shared types and constants of the first-fit page range allocator.
// ----------------------------------------------------------------------------
package ffpa_pkg;

  localparam int DEF_MAX_RANGES       = 32;
  localparam int DEF_PAGE_NUMBER_BITS = 40;

  typedef enum logic {
    ACT_FREE  = 1'b0,
    ACT_ALLOC = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_NO_RESOURCES = 2'd1,
    ST_TABLE_FULL   = 2'd2
  } status_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

endpackage

[sv/ffpa_alu.sv]
// ----------------------------------------------------------------------------
// ffpa_alu
// Shared add/subtract unit; carry is carry-out on add and borrow on subtract.
// ----------------------------------------------------------------------------
module ffpa_alu #(
  parameter int W = ffpa_pkg::DEF_PAGE_NUMBER_BITS
) (
  input  ffpa_pkg::alu_op_t op,
  input  logic [W-1:0]      a,
  input  logic [W-1:0]      b,
  output logic [W-1:0]      res,
  output logic              carry
);

  logic [W:0] full;

  always_comb begin
    case (op)
      ffpa_pkg::ALU_ADD: full = {1'b0, a} + {1'b0, b};
      ffpa_pkg::ALU_SUB: full = {1'b0, a} - {1'b0, b};
      default:           full = '0;
    endcase
  end

  assign res   = full[W-1:0];
  assign carry = full[W];

endmodule

[sv/ffpa_table.sv]
// ----------------------------------------------------------------------------
// ffpa_table
// Range table memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ffpa_table #(
  parameter int DEPTH = ffpa_pkg::DEF_MAX_RANGES,
  parameter int AW    = $clog2(ffpa_pkg::DEF_MAX_RANGES),
  parameter int DW    = 2 * ffpa_pkg::DEF_PAGE_NUMBER_BITS
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

[sv/first_fit_page_range_allocator_core.sv]
// ----------------------------------------------------------------------------
// first_fit_page_range_allocator_core
// First-fit allocator over an ordered table of free page ranges, built as a
// small sequencer around one shared adder and one table memory.
// ----------------------------------------------------------------------------
// Sequence: a set-up step, then a scan of the table that ends on the first hit
//   or after the last entry on a miss, then a grant or merge step and, when
//   entries move, a shift to close or open a gap; the result strobes as busy falls.
// Flow: one transaction at a time; the longest case is a merge at the tail,
//   and the scan and shifts are bounded by the single read port.
// Reset: synchronous, empties the table; the receiver cannot stall results.
module first_fit_page_range_allocator_core #(
  parameter int MAX_RANGES       = ffpa_pkg::DEF_MAX_RANGES,
  parameter int PAGE_NUMBER_BITS = ffpa_pkg::DEF_PAGE_NUMBER_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_action,
  input  logic [PAGE_NUMBER_BITS-1:0] in_page_number,
  input  logic [PAGE_NUMBER_BITS-1:0] in_page_total,
  output logic                        out_valid,
  output logic [1:0]                  out_status,
  output logic [PAGE_NUMBER_BITS-1:0] out_granted_page
);

  localparam int PW = PAGE_NUMBER_BITS;
  localparam int AW = $clog2(MAX_RANGES);
  localparam int CW = $clog2(MAX_RANGES + 1);
  localparam int DW = 2 * PW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_SCAN,
    S_AGRANT,
    S_FMERGE,
    S_SHDN,
    S_SHUP
  } state_t;

  state_t                state_r, state_nxt;
  logic                  out_valid_r, out_valid_nxt;
  ffpa_pkg::status_t     status_r, status_nxt;
  logic [PW-1:0]         granted_r, granted_nxt;
  logic [CW-1:0]         used_r, used_nxt;
  logic [CW-1:0]         ra_r, ra_nxt;
  logic                  rdv_r, rdv_nxt;
  logic [AW-1:0]         ci_r, ci_nxt;

  ffpa_pkg::action_t     act_r, act_nxt;
  logic [PW-1:0]         page_r, page_nxt;
  logic [PW-1:0]         cnt_r, cnt_nxt;
  logic [PW-1:0]         end_r, end_nxt;
  logic                  end_ovf_r, end_ovf_nxt;
  logic [AW-1:0]         k_r, k_nxt;
  logic [PW-1:0]         start_r, start_nxt;
  logic [PW-1:0]         len_r, len_nxt;

  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [DW-1:0]         wr_data;
  logic [AW-1:0]         rd_addr;
  logic [DW-1:0]         rd_data;
  logic [PW-1:0]         rd_start;
  logic [PW-1:0]         rd_len;

  ffpa_pkg::alu_op_t     alu_op;
  logic [PW-1:0]         alu_a;
  logic [PW-1:0]         alu_b;
  logic [PW-1:0]         alu_res;
  logic                  alu_carry;
  logic                  hit;

  assign rd_start = rd_data[DW-1:PW];
  assign rd_len   = rd_data[PW-1:0];

  ffpa_table #(
    .DEPTH (MAX_RANGES),
    .AW    (AW),
    .DW    (DW)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ffpa_alu #(
    .W (PW)
  ) u_alu (
    .op    (alu_op),
    .a     (alu_a),
    .b     (alu_b),
    .res   (alu_res),
    .carry (alu_carry)
  );

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    status_nxt    = status_r;
    granted_nxt   = granted_r;
    used_nxt      = used_r;
    ra_nxt        = ra_r;
    rdv_nxt       = 1'b0;
    ci_nxt        = ci_r;
    act_nxt       = act_r;
    page_nxt      = page_r;
    cnt_nxt       = cnt_r;
    end_nxt       = end_r;
    end_ovf_nxt   = end_ovf_r;
    k_nxt         = k_r;
    start_nxt     = start_r;
    len_nxt       = len_r;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = '0;
    rd_addr       = ra_r[AW-1:0];
    alu_op        = ffpa_pkg::ALU_ADD;
    alu_a         = '0;
    alu_b         = '0;
    hit           = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          act_nxt   = ffpa_pkg::action_t'(in_action);
          page_nxt  = in_page_number;
          cnt_nxt   = in_page_total;
          state_nxt = S_SETUP;
        end
      end

      S_SETUP: begin
        alu_a       = page_r;
        alu_b       = cnt_r;
        end_nxt     = alu_res;
        end_ovf_nxt = alu_carry;
        ra_nxt      = '0;
        state_nxt   = S_SCAN;
      end

      S_SCAN: begin
        alu_op = ffpa_pkg::ALU_SUB;
        if (act_r == ffpa_pkg::ACT_ALLOC) begin
          alu_a = rd_len;
          alu_b = cnt_r;
          hit   = rdv_r && !alu_carry;
        end else begin
          alu_a = rd_start;
          alu_b = end_r;
          hit   = rdv_r && !end_ovf_r && (alu_res == '0);
        end
        if (ra_r < used_r) begin
          rdv_nxt = 1'b1;
          ci_nxt  = ra_r[AW-1:0];
          ra_nxt  = ra_r + CW'(1);
        end
        if (hit) begin
          rdv_nxt   = 1'b0;
          k_nxt     = ci_r;
          start_nxt = rd_start;
          if (act_r == ffpa_pkg::ACT_ALLOC) begin
            len_nxt   = alu_res;
            state_nxt = S_AGRANT;
          end else begin
            len_nxt   = rd_len;
            state_nxt = S_FMERGE;
          end
        end else if (ra_r >= used_r) begin
          granted_nxt   = '0;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (act_r == ffpa_pkg::ACT_ALLOC) begin
            status_nxt = ffpa_pkg::ST_NO_RESOURCES;
          end else if (used_r >= CW'(MAX_RANGES)) begin
            status_nxt = ffpa_pkg::ST_TABLE_FULL;
          end else begin
            wr_en      = 1'b1;
            wr_addr    = used_r[AW-1:0];
            wr_data    = {page_r, cnt_r};
            used_nxt   = used_r + CW'(1);
            status_nxt = ffpa_pkg::ST_OK;
          end
        end
      end

      S_AGRANT: begin
        alu_a       = start_r;
        alu_b       = len_r;
        granted_nxt = alu_res;
        status_nxt  = ffpa_pkg::ST_OK;
        if (len_r != '0) begin
          wr_en         = 1'b1;
          wr_addr       = k_r;
          wr_data       = {start_r, len_r};
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          ra_nxt    = CW'(k_r) + CW'(1);
          state_nxt = S_SHDN;
        end
      end

      S_SHDN: begin
        if (rdv_r) begin
          wr_en   = 1'b1;
          wr_addr = ci_r - AW'(1);
          wr_data = rd_data;
        end
        if (ra_r < used_r) begin
          rdv_nxt = 1'b1;
          ci_nxt  = ra_r[AW-1:0];
          ra_nxt  = ra_r + CW'(1);
        end else if (!rdv_r) begin
          used_nxt      = used_r - CW'(1);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      S_FMERGE: begin
        alu_a       = len_r;
        alu_b       = cnt_r;
        len_nxt     = alu_carry ? '1 : alu_res;
        ra_nxt      = CW'(k_r);
        status_nxt  = ffpa_pkg::ST_OK;
        granted_nxt = '0;
        state_nxt   = S_SHUP;
      end

      S_SHUP: begin
        rd_addr = ra_r[AW-1:0] - AW'(1);
        if (rdv_r) begin
          wr_en   = 1'b1;
          wr_addr = ci_r + AW'(1);
          wr_data = rd_data;
        end
        if (ra_r != '0) begin
          rdv_nxt = 1'b1;
          ci_nxt  = ra_r[AW-1:0] - AW'(1);
          ra_nxt  = ra_r - CW'(1);
        end else if (!rdv_r) begin
          wr_en         = 1'b1;
          wr_addr       = '0;
          wr_data       = {page_r, len_r};
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      status_r    <= ffpa_pkg::ST_OK;
      granted_r   <= '0;
      used_r      <= '0;
      ra_r        <= '0;
      rdv_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      status_r    <= status_nxt;
      granted_r   <= granted_nxt;
      used_r      <= used_nxt;
      ra_r        <= ra_nxt;
      rdv_r       <= rdv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ci_r      <= ci_nxt;
    act_r     <= act_nxt;
    page_r    <= page_nxt;
    cnt_r     <= cnt_nxt;
    end_r     <= end_nxt;
    end_ovf_r <= end_ovf_nxt;
    k_r       <= k_nxt;
    start_r   <= start_nxt;
    len_r     <= len_nxt;
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_granted_page = granted_r;

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CW'(MAX_RANGES))
    else $error("entry count exceeds table depth");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  a_result_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_IDLE) && $past(busy))
    else $error("result strobe outside end of transaction");

  a_full_on_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (status_r == ffpa_pkg::ST_TABLE_FULL) |->
      (act_r == ffpa_pkg::ACT_FREE) && (used_r == CW'(MAX_RANGES)))
    else $error("table full reported without a full table on free");

  a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (status_r != ffpa_pkg::ST_OK) |-> (granted_r == '0))
    else $error("nonzero grant on failed transaction");

endmodule
